// ===== sv/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg
// Types, codes and small helpers shared by the Sv32 split-access walker.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

   // csr register indexes
   localparam logic CsrTranslationEnable = 1'b0;
   localparam logic CsrRootPageNumber    = 1'b1;
   localparam int   CsrDataWidth         = 22;

   // request codes
   localparam logic [1:0] ReqRead     = 2'd0;
   localparam logic [1:0] ReqWrite    = 2'd1;
   localparam logic [1:0] ReqResponse = 2'd2;

   // result codes
   localparam logic [1:0] KindRdReq  = 2'd0;
   localparam logic [1:0] KindWrReq  = 2'd1;
   localparam logic [1:0] KindRdData = 2'd2;
   localparam logic [1:0] KindFault  = 2'd3;

   localparam logic [2:0] EntryBytes = 3'd4;
   localparam logic [12:0] PageBytes = 13'd4096;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_WAIT_PDE  = 4'b0010,
      PH_WAIT_PTE  = 4'b0100,
      PH_WAIT_DATA = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] virtual_address;
      logic [2:0]  access_length;
      logic [31:0] write_data;
      logic [31:0] response_data;
   } item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] phys_address;
      logic [31:0] data_value;
      logic [2:0]  byte_count;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic                       translation_enable;
      logic [CsrDataWidth-1:0]    root_page_number;
   } cfg_type;

   // results handed from the walk logic to the result queue
   typedef struct packed {
      logic [1:0] push_count;
      result_type res0;
      result_type res1;
   } push_type;

   function automatic logic [31:0] byte_mask(input logic [2:0] n);
      logic [31:0] m;
      unique case (n)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   // directory entry address: root page base plus the vpn[1] slot
   function automatic logic [31:0] dir_addr(input logic [CsrDataWidth-1:0] root,
                                            input logic [31:0] va);
      return {root[19:0], va[31:22], 2'b00};
   endfunction

   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [31:0] addr,
                                              input logic [31:0] data,
                                              input logic [2:0] count,
                                              input logic last);
      result_type r;
      r.result_kind  = kind;
      r.phys_address = addr;
      r.data_value   = data;
      r.byte_count   = count;
      r.last_of_run  = last;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/swa_if.sv =====
// ----------------------------------------------------------------------------
// swa channel interfaces
// Valid/ready channels for requests, results and csr writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface swa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] virtual_address;
   logic [2:0]  access_length;
   logic [31:0] write_data;
   logic [31:0] response_data;

   modport source (output valid, req_type, virtual_address, access_length,
                   write_data, response_data, input ready);
   modport sink (input valid, req_type, virtual_address, access_length,
                 write_data, response_data, output ready);
endinterface

interface swa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] phys_address;
   logic [31:0] data_value;
   logic [2:0]  byte_count;
   logic        last_of_run;

   modport source (output valid, result_kind, phys_address, data_value,
                   byte_count, last_of_run, input ready);
   modport sink (input valid, result_kind, phys_address, data_value,
                 byte_count, last_of_run, output ready);
endinterface

interface swa_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [21:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/sv32_page_walk_split_access.sv =====
// ----------------------------------------------------------------------------
// sv32_page_walk_split_access
// Sv32 access unit: CPU reads and writes of 1 to 4 bytes and memory read
// responses come in on one channel; memory requests, read data and faults
// leave on the result channel. With translation on, each access walks the
// directory and table entries, and an access crossing a 4 KiB page runs two
// walks whose read halves are merged. The unit takes one item per cycle
// while the result queue has room: an accepted item is held in the input
// register, is decided there and lands in a two-entry result queue, which
// then offers its results on the result channel. Only the table entry of a
// split write's first page produces two results; any item whose results do
// not fit in the queue waits in the input register until the receiver has
// drained enough of it, which stalls the input. Csr writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module sv32_page_walk_split_access (
   input  wire logic clock,
   input  wire logic reset,
   swa_req_if.sink   req_chan,
   swa_rsp_if.source rsp_chan,
   swa_csr_if.sink   csr_chan
);

   logic              in_valid_ff, in_valid_in;
   swa_pkg::item_type in_item_ff;
   swa_pkg::cfg_type  cfg_ff;
   logic              req_fire;
   logic              item_take;
   logic [1:0]        free_slots;
   swa_pkg::push_type push;

   assign req_chan.ready = !in_valid_ff || item_take;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_fire || (in_valid_ff && !item_take);
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.req_type        <= req_chan.req_type;
         in_item_ff.virtual_address <= req_chan.virtual_address;
         in_item_ff.access_length   <= req_chan.access_length;
         in_item_ff.write_data      <= req_chan.write_data;
         in_item_ff.response_data   <= req_chan.response_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            swa_pkg::CsrTranslationEnable: cfg_ff.translation_enable <= csr_chan.data[0];
            swa_pkg::CsrRootPageNumber:    cfg_ff.root_page_number   <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   swa_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .cfg        (cfg_ff),
      .free_slots (free_slots),
      .item_take  (item_take),
      .push       (push)
   );

   swa_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .free_slots (free_slots),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== sv/swa_core.sv =====
// ----------------------------------------------------------------------------
// swa_core
// Walk state and the single-pass decision for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire swa_pkg::item_type item,
   input  wire swa_pkg::cfg_type  cfg,
   input  wire logic [1:0]        free_slots,
   output logic                   item_take,
   output swa_pkg::push_type      push
);

   swa_pkg::phase_type phase_ff, phase_in;
   logic [31:0] saved_address_ff, saved_address_in;
   logic [2:0]  saved_length_ff, saved_length_in;
   logic [31:0] saved_write_value_ff, saved_write_value_in;
   logic        is_write_access_ff, is_write_access_in;
   logic [2:0]  first_part_bytes_ff, first_part_bytes_in;
   logic        on_second_part_ff, on_second_part_in;
   logic [31:0] first_part_value_ff, first_part_value_in;

   logic        is_cpu;
   logic        bad_len;
   logic [12:0] off_sum;
   logic [12:0] first_room;
   logic [31:0] next_page_va;
   logic [31:0] part_va;
   logic [2:0]  part_n;
   logic        split;
   logic [31:0] pte_base;
   logic [4:0]  merge_shift;
   logic [31:0] wr_val;
   logic [31:0] rd_val;
   logic [1:0]  nres;
   swa_pkg::result_type res0, res1;

   assign is_cpu       = (item.req_type == swa_pkg::ReqRead) ||
                         (item.req_type == swa_pkg::ReqWrite);
   assign bad_len      = (item.access_length == 3'd0) ||
                         (item.access_length[2] && (item.access_length[1:0] != 2'd0));
   assign off_sum      = {1'b0, item.virtual_address[11:0]} + {10'd0, item.access_length};
   assign first_room   = swa_pkg::PageBytes - {1'b0, item.virtual_address[11:0]};
   // second part starts on the next page, wrapping at the top of the space
   assign next_page_va = {saved_address_ff[31:12] + 20'd1, 12'h000};
   assign part_va      = on_second_part_ff ? next_page_va : saved_address_ff;
   assign part_n       = on_second_part_ff ? (saved_length_ff - first_part_bytes_ff)
                                           : first_part_bytes_ff;
   assign split        = first_part_bytes_ff < saved_length_ff;
   assign pte_base     = {item.response_data[29:10], 12'h000};
   assign merge_shift  = {first_part_bytes_ff[1:0], 3'b000};
   assign wr_val       = (on_second_part_ff ? (saved_write_value_ff >> merge_shift)
                                            : saved_write_value_ff)
                         & swa_pkg::byte_mask(part_n);
   assign rd_val       = item.response_data & swa_pkg::byte_mask(part_n);

   always_comb begin
      phase_in             = phase_ff;
      saved_address_in     = saved_address_ff;
      saved_length_in      = saved_length_ff;
      saved_write_value_in = saved_write_value_ff;
      is_write_access_in   = is_write_access_ff;
      first_part_bytes_in  = first_part_bytes_ff;
      on_second_part_in    = on_second_part_ff;
      first_part_value_in  = first_part_value_ff;
      nres                 = 2'd0;
      res0                 = '0;
      res1                 = '0;
      priority if (is_cpu) begin
         nres = 2'd1;
         priority if ((phase_ff != swa_pkg::PH_IDLE) || bad_len) begin
            res0 = swa_pkg::make_result(swa_pkg::KindFault, item.virtual_address,
                                        32'd0, item.access_length, 1'b1);
         end else if (!cfg.translation_enable) begin
            if (item.req_type == swa_pkg::ReqWrite) begin
               res0 = swa_pkg::make_result(swa_pkg::KindWrReq, item.virtual_address,
                         item.write_data & swa_pkg::byte_mask(item.access_length),
                         item.access_length, 1'b1);
            end else begin
               saved_address_in    = item.virtual_address;
               saved_length_in     = item.access_length;
               first_part_bytes_in = item.access_length;
               on_second_part_in   = 1'b0;
               is_write_access_in  = 1'b0;
               first_part_value_in = 32'd0;
               phase_in            = swa_pkg::PH_WAIT_DATA;
               res0 = swa_pkg::make_result(swa_pkg::KindRdReq, item.virtual_address,
                                           32'd0, item.access_length, 1'b1);
            end
         end else begin
            saved_address_in     = item.virtual_address;
            saved_length_in      = item.access_length;
            saved_write_value_in = item.write_data;
            is_write_access_in   = (item.req_type == swa_pkg::ReqWrite);
            first_part_bytes_in  = (off_sum > swa_pkg::PageBytes) ? first_room[2:0]
                                                                   : item.access_length;
            on_second_part_in    = 1'b0;
            first_part_value_in  = 32'd0;
            phase_in             = swa_pkg::PH_WAIT_PDE;
            res0 = swa_pkg::make_result(swa_pkg::KindRdReq,
                      swa_pkg::dir_addr(cfg.root_page_number, item.virtual_address),
                      32'd0, swa_pkg::EntryBytes, 1'b1);
         end
      end else if ((item.req_type == swa_pkg::ReqResponse) &&
                   (phase_ff != swa_pkg::PH_IDLE)) begin
         nres = 2'd1;
         unique case (phase_ff)
            swa_pkg::PH_WAIT_PDE, swa_pkg::PH_WAIT_PTE: begin
               priority if (!item.response_data[0]) begin
                  res0 = swa_pkg::make_result(swa_pkg::KindFault, part_va, 32'd0,
                                              saved_length_ff, 1'b1);
                  phase_in = swa_pkg::PH_IDLE;
               end else if (phase_ff == swa_pkg::PH_WAIT_PDE) begin
                  res0 = swa_pkg::make_result(swa_pkg::KindRdReq,
                            pte_base | {20'd0, part_va[21:12], 2'b00},
                            32'd0, swa_pkg::EntryBytes, 1'b1);
                  phase_in = swa_pkg::PH_WAIT_PTE;
               end else if (is_write_access_ff) begin
                  if (!on_second_part_ff && split) begin
                     // first half goes out with the walk for the next page
                     nres = 2'd2;
                     res0 = swa_pkg::make_result(swa_pkg::KindWrReq,
                               pte_base | {20'd0, part_va[11:0]}, wr_val, part_n, 1'b0);
                     res1 = swa_pkg::make_result(swa_pkg::KindRdReq,
                               swa_pkg::dir_addr(cfg.root_page_number, next_page_va),
                               32'd0, swa_pkg::EntryBytes, 1'b1);
                     on_second_part_in = 1'b1;
                     phase_in          = swa_pkg::PH_WAIT_PDE;
                  end else begin
                     res0 = swa_pkg::make_result(swa_pkg::KindWrReq,
                               pte_base | {20'd0, part_va[11:0]}, wr_val, part_n, 1'b1);
                     phase_in = swa_pkg::PH_IDLE;
                  end
               end else begin
                  res0 = swa_pkg::make_result(swa_pkg::KindRdReq,
                            pte_base | {20'd0, part_va[11:0]}, 32'd0, part_n, 1'b1);
                  phase_in = swa_pkg::PH_WAIT_DATA;
               end
            end
            swa_pkg::PH_WAIT_DATA: begin
               if (!on_second_part_ff && split) begin
                  first_part_value_in = rd_val;
                  on_second_part_in   = 1'b1;
                  phase_in            = swa_pkg::PH_WAIT_PDE;
                  res0 = swa_pkg::make_result(swa_pkg::KindRdReq,
                            swa_pkg::dir_addr(cfg.root_page_number, next_page_va),
                            32'd0, swa_pkg::EntryBytes, 1'b1);
               end else begin
                  res0 = swa_pkg::make_result(swa_pkg::KindRdData, 32'd0,
                            on_second_part_ff ? (first_part_value_ff | (rd_val << merge_shift))
                                              : rd_val,
                            saved_length_ff, 1'b1);
                  phase_in = swa_pkg::PH_IDLE;
               end
            end
            default: begin
               nres = 2'd0;
            end
         endcase
      end else begin
         nres = 2'd0;
      end
   end

   assign item_take       = item_valid && (nres <= free_slots);
   assign push.push_count = item_take ? nres : 2'd0;
   assign push.res0       = res0;
   assign push.res1       = res1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= swa_pkg::PH_IDLE;
         is_write_access_ff <= 1'b0;
         on_second_part_ff  <= 1'b0;
      end else if (item_take) begin
         phase_ff           <= phase_in;
         is_write_access_ff <= is_write_access_in;
         on_second_part_ff  <= on_second_part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         saved_address_ff     <= saved_address_in;
         saved_length_ff      <= saved_length_in;
         saved_write_value_ff <= saved_write_value_in;
         first_part_bytes_ff  <= first_part_bytes_in;
         first_part_value_ff  <= first_part_value_in;
      end
   end

`ifndef SYNTHESIS
   a_two_results: assert property (@(posedge clock) disable iff (reset)
      (push.push_count == 2'd2) |->
         ((push.res0.result_kind == swa_pkg::KindWrReq) && !push.res0.last_of_run &&
          (push.res1.result_kind == swa_pkg::KindRdReq) && push.res1.last_of_run))
      else $error("two-result transfer is not a split write plus walk");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (push.push_count == 2'd1) |-> push.res0.last_of_run)
      else $error("single result without last flag");
   a_fault_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (item_take && (item.req_type == swa_pkg::ReqResponse) &&
       (push.push_count == 2'd1) && (push.res0.result_kind == swa_pkg::KindFault))
      |=> (phase_ff == swa_pkg::PH_IDLE))
      else $error("walk still busy after an entry fault");
`endif

endmodule

`default_nettype wire

// ===== sv/swa_outq.sv =====
// ----------------------------------------------------------------------------
// swa_outq
// Two-entry result queue that drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_outq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire swa_pkg::push_type push,
   output logic [1:0]             free_slots,
   swa_rsp_if.source              rsp_chan
);

   logic [1:0] count_ff, count_in;
   swa_pkg::result_type slot_ff [2];
   swa_pkg::result_type slot_in [2];
   logic       pop;
   logic [1:0] remain;

   assign pop        = (count_ff != 2'd0) && rsp_chan.ready;
   assign free_slots = 2'd2 - count_ff + {1'b0, pop};
   assign remain     = count_ff - {1'b0, pop};

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push.push_count != 2'd0) begin
         if (remain == 2'd0) begin
            slot_in[0] = push.res0;
         end else begin
            slot_in[1] = push.res0;
         end
      end
      if (push.push_count == 2'd2) begin
         slot_in[1] = push.res1;
      end
      count_in = remain + push.push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign rsp_chan.valid        = count_ff != 2'd0;
   assign rsp_chan.result_kind  = slot_ff[0].result_kind;
   assign rsp_chan.phys_address = slot_ff[0].phys_address;
   assign rsp_chan.data_value   = slot_ff[0].data_value;
   assign rsp_chan.byte_count   = slot_ff[0].byte_count;
   assign rsp_chan.last_of_run  = slot_ff[0].last_of_run;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push_count <= free_slots)
      else $error("result queue overflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");
   a_drain_shift: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd2) && pop && (push.push_count == 2'd0)) |=>
         ((count_ff == 2'd1) && (slot_ff[0] == $past(slot_ff[1]))))
      else $error("result queue lost its second entry");
`endif

endmodule

`default_nettype wire
